### hdl/timer_queue_engine_defines.svh
// Assertion macros for the timer queue engine.
`ifndef TIMER_QUEUE_ENGINE_DEFINES_SVH
`define TIMER_QUEUE_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TQE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`define TQE_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`else
`define TQE_ASSERT_NEXT(label, ante, cons, msg)
`define TQE_ASSERT_ALWAYS(label, cond, msg)
`endif
`endif

### hdl/tqe_pkg.sv
// Shared types, constants and functions of the timer queue engine.
`default_nettype none
package tqe_pkg;
   localparam int TIME_W           = 48;
   localparam int ID_W             = 32;
   localparam int SLOT_IDX_W       = 8;
   localparam int SLOTS_DEFAULT    = 16;
   localparam int MAX_FIRE_DEFAULT = 16;
   localparam int RESULT_CAP       = 16;

   localparam logic [1:0] KIND_ADD     = 2'd0;
   localparam logic [1:0] KIND_DELETE  = 2'd1;
   localparam logic [1:0] KIND_ADVANCE = 2'd2;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_CLEAR,
      CMD_FIRE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type              op;
      logic [SLOT_IDX_W-1:0]   idx;
      logic [TIME_W-1:0]       expiry;
      logic [ID_W-1:0]         id;
      logic [TIME_W-1:0]       period;
   } cmd_type;

   typedef struct packed {
      logic                    first_found;
      logic [TIME_W-1:0]       first_expiry;
      logic [ID_W-1:0]         first_id;
      logic [SLOT_IDX_W-1:0]   first_idx;
      logic                    match_found;
      logic [TIME_W-1:0]       match_expiry;
      logic [ID_W-1:0]         match_id;
      logic [SLOT_IDX_W-1:0]   match_idx;
      logic                    free_found;
      logic [SLOT_IDX_W-1:0]   free_idx;
   } carry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETTLE,
      ST_DECIDE
   } state_type;

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
   endfunction

   function automatic logic earlier(input logic [TIME_W-1:0] ea, input logic [ID_W-1:0] ia,
                                    input logic [TIME_W-1:0] eb, input logic [ID_W-1:0] ib);
      return (ea < eb) || ((ea == eb) && (ia < ib));
   endfunction
endpackage
`default_nettype wire

### hdl/tqe_cell.sv
// One timer slot with its stage of the earliest, match and free search chain.
`default_nettype none
module tqe_cell #(
   parameter int INDEX = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tqe_pkg::cmd_type   cmd,
   input  wire logic [31:0]        target,
   input  wire tqe_pkg::carry_type carry_in,
   output tqe_pkg::carry_type      carry_out
);
   import tqe_pkg::*;

   logic                  valid_ff, valid_in;
   logic [TIME_W-1:0]     expiry_ff, expiry_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [TIME_W-1:0]     period_ff, period_in;
   carry_type             carry_ff, carry_in_next;
   logic                  hit;

   assign hit = (cmd.idx == SLOT_IDX_W'(INDEX));

   always_comb begin
      valid_in  = valid_ff;
      expiry_in = expiry_ff;
      id_in     = id_ff;
      period_in = period_ff;
      if (hit) begin
         unique case (cmd.op)
            CMD_LOAD: begin
               valid_in  = 1'b1;
               expiry_in = cmd.expiry;
               id_in     = cmd.id;
               period_in = cmd.period;
            end
            CMD_CLEAR: valid_in = 1'b0;
            CMD_FIRE: begin
               if (period_ff != '0) expiry_in = sat_add(expiry_ff, period_ff);
               else valid_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      carry_in_next = carry_in;
      if (valid_ff && (!carry_in.first_found ||
          earlier(expiry_ff, id_ff, carry_in.first_expiry, carry_in.first_id))) begin
         carry_in_next.first_found  = 1'b1;
         carry_in_next.first_expiry = expiry_ff;
         carry_in_next.first_id     = id_ff;
         carry_in_next.first_idx    = SLOT_IDX_W'(INDEX);
      end
      if (valid_ff && (id_ff == target) && (!carry_in.match_found ||
          earlier(expiry_ff, id_ff, carry_in.match_expiry, carry_in.match_id))) begin
         carry_in_next.match_found  = 1'b1;
         carry_in_next.match_expiry = expiry_ff;
         carry_in_next.match_id     = id_ff;
         carry_in_next.match_idx    = SLOT_IDX_W'(INDEX);
      end
      if (!valid_ff && !carry_in.free_found) begin
         carry_in_next.free_found = 1'b1;
         carry_in_next.free_idx   = SLOT_IDX_W'(INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      expiry_ff <= expiry_in;
      id_ff     <= id_in;
      period_ff <= period_in;
      carry_ff  <= carry_in_next;
   end

   assign carry_out = carry_ff;
endmodule
`default_nettype wire

### hdl/timer_queue_engine.sv
// Top level of the timer queue engine: sequencer, result register and the row of slot cells.
//  channel | dir | tdata                          | tuser                     | tlast
//  req     | in  | now,delay,repeat_interval,tgt  | kind                      | -
//  rsp     | out | result_id                      | earliest_changed,fired,full | last
// Every kind waits in SETTLE while the search chain runs through the cells, one cell
// per cycle, then acts in DECIDE; an advance goes back to SETTLE after each firing
// and finishes with a last DECIDE that gives the final result.
// Reset clears all slot valid bits and the id counter at once.
// A stalled result holds in the output register; the next request is taken meanwhile.
`default_nettype none
`include "timer_queue_engine_defines.svh"
module timer_queue_engine #(
   parameter int SLOTS    = tqe_pkg::SLOTS_DEFAULT,
   parameter int MAX_FIRE = tqe_pkg::MAX_FIRE_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // now_time[47:0], delay[95:48], repeat_interval[143:96], target_id[175:144]
   input  wire logic [175:0] req_tdata,
   // kind[1:0]
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // result_id[31:0]
   output logic [31:0]       rsp_tdata,
   // earliest_changed[0], fired[1], store_full[2]
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast
);
   import tqe_pkg::*;

   localparam int LIMIT      = (MAX_FIRE < RESULT_CAP) ? MAX_FIRE : RESULT_CAP;
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int FIRE_CNT_W = $clog2(LIMIT + 1);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [1:0]             kind_ff, kind_in;
   logic [TIME_W-1:0]      now_ff, now_in, delay_ff, delay_in, period_ff, period_in;
   logic [ID_W-1:0]        target_ff, target_in;
   logic [ID_W-1:0]        id_counter_ff, id_counter_in;
   logic                   held_valid_ff, held_valid_in;
   logic [ID_W-1:0]        held_id_ff, held_id_in;
   logic [FIRE_CNT_W-1:0]  fire_cnt_ff, fire_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_id_ff, rsp_id_in;
   logic [2:0]             rsp_flags_ff, rsp_flags_in;
   logic                   rsp_last_ff, rsp_last_in;
   cmd_type                cmd;
   carry_type              carry [0:SLOTS];
   carry_type              res;
   logic                   out_free;
   logic [TIME_W-1:0]      new_expiry;
   logic                   fire_now;

   assign carry[0] = '0;
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      tqe_cell #(.INDEX(g)) u_cell (
         .clock(clock), .reset(reset), .cmd(cmd), .target(target_ff),
         .carry_in(carry[g]), .carry_out(carry[g+1])
      );
   end
   assign res = carry[SLOTS];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign new_expiry = sat_add(now_ff, delay_ff);
   assign fire_now   = res.first_found && (res.first_expiry < now_ff) &&
                       (fire_cnt_ff < FIRE_CNT_W'(LIMIT));
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      kind_in       = kind_ff;
      now_in        = now_ff;
      delay_in      = delay_ff;
      period_in     = period_ff;
      target_in     = target_ff;
      id_counter_in = id_counter_ff;
      held_valid_in = held_valid_ff;
      held_id_in    = held_id_ff;
      fire_cnt_in   = fire_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_id_in     = rsp_id_ff;
      rsp_flags_in  = rsp_flags_ff;
      rsp_last_in   = rsp_last_ff;
      cmd           = '0;
      cmd.op        = CMD_NONE;
      cmd.expiry    = new_expiry;
      cmd.id        = id_counter_ff + 32'd1;
      cmd.period    = period_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in       = req_tuser;
               now_in        = req_tdata[47:0];
               delay_in      = req_tdata[95:48];
               period_in     = req_tdata[143:96];
               target_in     = req_tdata[175:144];
               cnt_in        = '0;
               fire_cnt_in   = '0;
               held_valid_in = 1'b0;
               state_in      = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SLOTS)) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (kind_ff == KIND_ADVANCE && fire_now) begin
               if (!held_valid_ff || out_free) begin
                  if (held_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_id_in    = held_id_ff;
                     rsp_flags_in = 3'b010;
                     rsp_last_in  = 1'b0;
                  end
                  held_valid_in = 1'b1;
                  held_id_in    = res.first_id;
                  fire_cnt_in   = fire_cnt_ff + FIRE_CNT_W'(1);
                  cmd.op        = CMD_FIRE;
                  cmd.idx       = res.first_idx;
                  cnt_in        = '0;
                  state_in      = ST_SETTLE;
               end
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = '0;
               rsp_flags_in = 3'b000;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
               priority if (kind_ff == KIND_ADD) begin
                  if (!res.free_found) begin
                     rsp_flags_in = 3'b100;
                  end else begin
                     rsp_id_in     = id_counter_ff + 32'd1;
                     rsp_flags_in  = {2'b00, !res.first_found ||
                                             (new_expiry < res.first_expiry)};
                     id_counter_in = id_counter_ff + 32'd1;
                     cmd.op        = CMD_LOAD;
                     cmd.idx       = res.free_idx;
                  end
               end else if (kind_ff == KIND_DELETE) begin
                  if (res.match_found) begin
                     rsp_flags_in = {2'b00, res.match_idx == res.first_idx};
                     cmd.op       = CMD_CLEAR;
                     cmd.idx      = res.match_idx;
                  end
               end else if (kind_ff == KIND_ADVANCE) begin
                  if (held_valid_ff) begin
                     rsp_id_in    = held_id_ff;
                     rsp_flags_in = 3'b010;
                  end
               end else begin
                  rsp_flags_in = 3'b000;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         id_counter_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         held_valid_ff <= 1'b0;
         fire_cnt_ff   <= '0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         id_counter_ff <= id_counter_in;
         rsp_valid_ff  <= rsp_valid_in;
         held_valid_ff <= held_valid_in;
         fire_cnt_ff   <= fire_cnt_in;
         cnt_ff        <= cnt_in;
      end
      kind_ff      <= kind_in;
      now_ff       <= now_in;
      delay_ff     <= delay_in;
      period_ff    <= period_in;
      target_ff    <= target_in;
      held_id_ff   <= held_id_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tuser  = rsp_flags_ff;
   assign rsp_tlast  = rsp_last_ff;

   `TQE_ASSERT_NEXT(a_busy_after_transfer, req_tvalid && req_tready, !req_tready, "ready after transfer")
   `TQE_ASSERT_ALWAYS(a_fire_limit, fire_cnt_ff <= FIRE_CNT_W'(LIMIT), "firing count over limit")
   `TQE_ASSERT_ALWAYS(a_fired_clean, !rsp_tvalid || !rsp_tuser[1] || (rsp_tuser == 3'b010), "bad fired flags")
endmodule
`default_nettype wire
